@@ sv/dgcd_pkg.sv @@
package dgcd_pkg;

  localparam int MaxNodes = 64;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);
  localparam int CfgW     = 7;
  localparam int StkW     = NodeW + CntW;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DRAIN,
    S_ROOT,
    S_FETCH,
    S_SCAN,
    S_POPRD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_en;
    logic root_step;
    logic root_push;
    logic latch_row;
    logic scan;
    logic pop_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_seen;
    logic col_end;
    logic col_edge;
    logic col_onpath;
    logic col_seen;
    logic stack_last;
    logic stack_full;
    logic out_busy;
  } stat_t;

endpackage

@@ sv/directed_graph_cycle_detect_unit.sv @@
// Edges load at one transfer per cycle; each edge is merged into its matrix row in the cycle after its transfer.
// After the last edge the depth-first search scans one matrix column per cycle while in its scan
// state, between row fetches and stack pops, and the result is written to the output register
// only once the previous result has been taken.
// No new edge is taken until the result is in the output register.
// Reset is synchronous and active low: it empties the matrix through per-row valid bits,
// clears the search marks, sets node_count to 64, and the block is ready in the next cycle.
module directed_graph_cycle_detect_unit
  import dgcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NodeW-1:0] in_src_node,
  input  logic [NodeW-1:0] in_dst_node,
  input  logic             in_edge_valid,
  input  logic             in_last_edge,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_has_cycle,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CfgW-1:0]  cfg_node_count
);

  cmd_t  cmd;
  stat_t st;

  dgcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_edge(in_last_edge),
    .st          (st),
    .cmd         (cmd)
  );

  dgcd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_valid      (in_valid),
    .in_src_node   (in_src_node),
    .in_dst_node   (in_dst_node),
    .in_edge_valid (in_edge_valid),
    .cfg_valid     (cfg_valid),
    .cfg_node_count(cfg_node_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_has_cycle (out_has_cycle)
  );

  assign in_ready  = cmd.load_en;
  assign cfg_ready = 1'b1;

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_edge) |=> !in_ready ##1 !in_ready)
    else $error("input accepted while the matrix write of the last edge was pending");

  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while edges were being loaded");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_en, cmd.root_step, cmd.root_push, cmd.latch_row,
              cmd.scan, cmd.pop_load, cmd.finish}))
    else $error("controller issued more than one command");

endmodule

@@ sv/dgcd_ram.sv @@
module dgcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dgcd_ctrl.sv @@
module dgcd_ctrl
  import dgcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_last_edge,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid && in_last_edge) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (st.root_done) begin
          state_nxt = S_DONE;
        end else if (!st.root_seen) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (st.col_end) begin
          state_nxt = st.stack_last ? S_ROOT : S_POPRD;
        end else if (st.col_edge && st.col_onpath) begin
          state_nxt = S_DONE;
        end else if (st.col_edge && !st.col_seen && !st.stack_full) begin
          state_nxt = S_FETCH;
        end
      end
      S_POPRD: begin
        state_nxt = S_FETCH;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load_en = 1'b1;
      end
      S_ROOT: begin
        cmd.root_step = !st.root_done && st.root_seen;
        cmd.root_push = !st.root_done && !st.root_seen;
      end
      S_FETCH: begin
        cmd.latch_row = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_POPRD: begin
        cmd.pop_load = 1'b1;
      end
      S_DONE: begin
        cmd.finish = !st.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ sv/dgcd_dp.sv @@
module dgcd_dp
  import dgcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            st,
  input  logic             in_valid,
  input  logic [NodeW-1:0] in_src_node,
  input  logic [NodeW-1:0] in_dst_node,
  input  logic             in_edge_valid,
  input  logic             cfg_valid,
  input  logic [CfgW-1:0]  cfg_node_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_has_cycle
);

  logic [CfgW-1:0]     node_count_r;
  logic [CntW-1:0]     n_live;

  logic [MaxNodes-1:0] row_vld_r;
  logic                ld_vld_r;
  logic [NodeW-1:0]    ld_src_r;
  logic [NodeW-1:0]    ld_dst_r;
  logic                fwd_vld_r;
  logic [NodeW-1:0]    fwd_addr_r;
  logic [MaxNodes-1:0] fwd_data_r;
  logic [MaxNodes-1:0] ld_row;
  logic                ld_keep;

  logic [NodeW-1:0]    adj_raddr;
  logic [MaxNodes-1:0] adj_rdata;

  logic [NodeW-1:0]    cur_u_r;
  logic [CntW-1:0]     cur_c_r;
  logic [CntW-1:0]     depth_r;
  logic [CntW-1:0]     root_r;
  logic [MaxNodes-1:0] visited_r;
  logic [MaxNodes-1:0] onpath_r;
  logic [MaxNodes-1:0] cur_row_r;
  logic                found_r;
  logic                out_valid_r;
  logic                out_has_cycle_r;

  logic [NodeW-1:0]    col;
  logic [NodeW-1:0]    root_idx;
  logic [CntW-1:0]     depth_m1;
  logic [CntW-1:0]     depth_m2;
  logic                do_push;
  logic                do_pop;
  logic                do_found;
  logic [StkW-1:0]     stk_wdata;
  logic [StkW-1:0]     stk_rdata;
  logic [NodeW-1:0]    stk_node;
  logic [CntW-1:0]     stk_col;

  assign n_live = (int'(node_count_r) > MaxNodes) ? CntW'(MaxNodes) : CntW'(node_count_r);

  assign ld_keep = in_edge_valid
                && (CntW'(in_src_node) < n_live)
                && (CntW'(in_dst_node) < n_live);

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == ld_src_r)) begin
      ld_row = fwd_data_r;
    end else if (row_vld_r[ld_src_r]) begin
      ld_row = adj_rdata;
    end else begin
      ld_row = '0;
    end
    ld_row = ld_row | (MaxNodes'(1) << ld_dst_r);
  end

  assign col      = cur_c_r[NodeW-1:0];
  assign root_idx = root_r[NodeW-1:0];
  assign depth_m1 = depth_r - CntW'(1);
  assign depth_m2 = depth_r - CntW'(2);
  assign stk_node = stk_rdata[StkW-1 -: NodeW];
  assign stk_col  = stk_rdata[CntW-1:0];

  assign st.root_done  = root_r >= n_live;
  assign st.root_seen  = visited_r[root_idx];
  assign st.col_end    = cur_c_r >= n_live;
  assign st.col_edge   = cur_row_r[col];
  assign st.col_onpath = onpath_r[col];
  assign st.col_seen   = visited_r[col];
  assign st.stack_last = depth_r == CntW'(1);
  assign st.stack_full = depth_r == CntW'(MaxNodes);
  assign st.out_busy   = out_valid_r && !out_ready;

  assign do_pop   = cmd.scan && st.col_end;
  assign do_found = cmd.scan && !st.col_end && st.col_edge && st.col_onpath;
  assign do_push  = cmd.scan && !st.col_end && st.col_edge && !st.col_onpath
                 && !st.col_seen && !st.stack_full;

  always_comb begin
    if (cmd.load_en) begin
      adj_raddr = in_src_node;
    end else if (cmd.root_push) begin
      adj_raddr = root_idx;
    end else if (cmd.pop_load) begin
      adj_raddr = stk_node;
    end else begin
      adj_raddr = col;
    end
  end

  assign stk_wdata = {cur_u_r, cur_c_r + CntW'(1)};

  dgcd_ram #(
    .WIDTH(MaxNodes),
    .DEPTH(MaxNodes)
  ) u_adj_ram (
    .clk  (clk),
    .we   (ld_vld_r),
    .waddr(ld_src_r),
    .wdata(ld_row),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  dgcd_ram #(
    .WIDTH(StkW),
    .DEPTH(MaxNodes)
  ) u_stk_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(depth_m1[NodeW-1:0]),
    .wdata(stk_wdata),
    .raddr(depth_m2[NodeW-1:0]),
    .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r    <= CfgW'(64);
      row_vld_r       <= '0;
      ld_vld_r        <= 1'b0;
      fwd_vld_r       <= 1'b0;
      depth_r         <= '0;
      root_r          <= '0;
      visited_r       <= '0;
      onpath_r        <= '0;
      found_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_count_r <= cfg_node_count;
      end
      ld_vld_r  <= cmd.load_en && in_valid && ld_keep;
      fwd_vld_r <= ld_vld_r;
      if (ld_vld_r) begin
        row_vld_r[ld_src_r] <= 1'b1;
      end
      if (cmd.root_step) begin
        root_r <= root_r + CntW'(1);
      end
      if (cmd.root_push) begin
        depth_r             <= CntW'(1);
        visited_r[root_idx] <= 1'b1;
        onpath_r[root_idx]  <= 1'b1;
      end
      if (do_push) begin
        depth_r        <= depth_r + CntW'(1);
        visited_r[col] <= 1'b1;
        onpath_r[col]  <= 1'b1;
      end
      if (do_pop) begin
        depth_r           <= depth_m1;
        onpath_r[cur_u_r] <= 1'b0;
      end
      if (do_found) begin
        found_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        row_vld_r   <= '0;
        depth_r     <= '0;
        root_r      <= '0;
        visited_r   <= '0;
        onpath_r    <= '0;
        found_r     <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_src_r   <= in_src_node;
    ld_dst_r   <= in_dst_node;
    fwd_addr_r <= ld_src_r;
    fwd_data_r <= ld_row;
    if (cmd.root_push) begin
      cur_u_r <= root_idx;
      cur_c_r <= '0;
    end else if (do_push) begin
      cur_u_r <= col;
      cur_c_r <= '0;
    end else if (cmd.pop_load) begin
      cur_u_r <= stk_node;
      cur_c_r <= stk_col;
    end else if (cmd.scan && !st.col_end) begin
      cur_c_r <= cur_c_r + CntW'(1);
    end
    if (cmd.latch_row) begin
      cur_row_r <= row_vld_r[cur_u_r] ? adj_rdata : '0;
    end
    if (cmd.finish) begin
      out_has_cycle_r <= found_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_has_cycle = out_has_cycle_r;

endmodule

@@ tb/graph_cycle_checker.sv @@
`timescale 1ns / 1ps

module graph_cycle_checker
  import dgcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [NodeW-1:0] in_src_node,
  input  logic [NodeW-1:0] in_dst_node,
  input  logic             in_edge_valid,
  input  logic             in_last_edge,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_has_cycle,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CfgW-1:0]  cfg_node_count,
  output int               verdicts_due,
  output int               mismatch_cnt
);

  logic [MaxNodes-1:0] adj_rows [MaxNodes];
  int                  dfs_node [MaxNodes];
  int                  dfs_col  [MaxNodes];
  logic [CfgW-1:0]     node_cnt = 7'd64;
  logic                verdict_q [$];
  int                  fail_cnt = 0;

  // Depth-first search from every unvisited root in ascending order; an edge
  // into a node on the current path means the graph has a cycle.
  function automatic logic find_cycle(input int n);
    logic [MaxNodes-1:0] seen;
    logic [MaxNodes-1:0] on_path;
    int depth, top, u, c;
    seen    = '0;
    on_path = '0;
    depth   = 0;
    for (int r = 0; r < n; r++) begin
      if (!seen[r]) begin
        seen[r]     = 1'b1;
        on_path[r]  = 1'b1;
        dfs_node[0] = r;
        dfs_col[0]  = 0;
        depth       = 1;
        while (depth > 0) begin
          top = depth - 1;
          u   = dfs_node[top];
          c   = dfs_col[top];
          while (c < n && !adj_rows[u][c]) c++;
          if (c >= n) begin
            on_path[u] = 1'b0;
            depth--;
          end else begin
            dfs_col[top] = c + 1;
            if (on_path[c]) return 1'b1;
            if (!seen[c] && depth < MaxNodes) begin
              seen[c]         = 1'b1;
              on_path[c]      = 1'b1;
              dfs_node[depth] = c;
              dfs_col[depth]  = 0;
              depth++;
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    int   lim;
    logic want;
    if (!rst_n) begin
      for (int i = 0; i < MaxNodes; i++) adj_rows[i] = '0;
      node_cnt = 7'd64;
      verdict_q.delete();
      verdicts_due <= 0;
      mismatch_cnt <= fail_cnt;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("has_cycle: expected none, actual %0b", out_has_cycle);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_has_cycle !== want) begin
            $error("has_cycle: expected %0b, actual %0b", want, out_has_cycle);
            fail_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) node_cnt = cfg_node_count;
      if (in_valid && in_ready) begin
        lim = (node_cnt > MaxNodes) ? MaxNodes : int'(node_cnt);
        if (in_edge_valid && in_src_node < lim && in_dst_node < lim)
          adj_rows[in_src_node][in_dst_node] = 1'b1;
        if (in_last_edge) begin
          verdict_q = {verdict_q, find_cycle(lim)};
          for (int i = 0; i < MaxNodes; i++) adj_rows[i] = '0;
        end
      end
      verdicts_due <= verdict_q.size();
      mismatch_cnt <= fail_cnt;
    end
  end

endmodule

@@ tb/directed_graph_cycle_detect_unit_tb.sv @@
`timescale 1ns / 1ps

module directed_graph_cycle_detect_unit_tb;
  import dgcd_pkg::*;

  localparam int CycleLimit   = 20000000;
  localparam int HoldCycles   = 600;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 16;

  typedef enum int {GK_DAG, GK_MESH, GK_RING} graph_kind_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [NodeW-1:0] in_src_node    = '0;
  logic [NodeW-1:0] in_dst_node    = '0;
  logic             in_edge_valid  = 1'b0;
  logic             in_last_edge   = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic             out_has_cycle;
  logic             cfg_valid      = 1'b0;
  logic             cfg_ready;
  logic [CfgW-1:0]  cfg_node_count = '0;

  int   verdicts_due;
  int   mismatch_cnt;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_go     = 1'b0;
  int   hold_left   = 0;
  int   cycle_cnt   = 0;
  int   items_sent  = 0;
  int   live_n      = 64;

  always #6 clk = ~clk;

  directed_graph_cycle_detect_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_src_node    (in_src_node),
    .in_dst_node    (in_dst_node),
    .in_edge_valid  (in_edge_valid),
    .in_last_edge   (in_last_edge),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_has_cycle  (out_has_cycle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  graph_cycle_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_src_node    (in_src_node),
    .in_dst_node    (in_dst_node),
    .in_edge_valid  (in_edge_valid),
    .in_last_edge   (in_last_edge),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_has_cycle  (out_has_cycle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count),
    .verdicts_due   (verdicts_due),
    .mismatch_cnt   (mismatch_cnt)
  );

  // The receiver stalls at random, or for a long stretch when asked to.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_edge(input int src, input int dst, input bit ev, input bit lst);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_src_node   <= NodeW'(src);
    in_dst_node   <= NodeW'(dst);
    in_edge_valid <= ev;
    in_last_edge  <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    wait_idle();
    cfg_valid      <= 1'b1;
    cfg_node_count <= CfgW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    live_n = (value > MaxNodes) ? MaxNodes : value;
  endtask

  // One graph: mostly edges of the chosen shape among live nodes, with some
  // empty items and some edges that may fall outside the graph.
  task automatic run_graph(input graph_kind_t kind, input int len);
    int s, d, a, head, prev, pick;
    bit ev, lst, close;
    head  = (live_n > 0) ? $urandom_range(live_n - 1) : 0;
    prev  = head;
    close = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      lst  = (i == len - 1);
      ev   = 1'b1;
      s    = $urandom_range(MaxNodes - 1);
      d    = $urandom_range(MaxNodes - 1);
      pick = $urandom_range(99);
      if (pick < 5) begin
        ev = 1'b0;
      end else if (pick >= 12 && live_n > 0) begin
        case (kind)
          GK_DAG: begin
            if (live_n > 1) begin
              a = $urandom_range(live_n - 2);
              s = a;
              d = $urandom_range(live_n - 1, a + 1);
            end else begin
              s = 0;
              d = 0;
            end
          end
          GK_RING: begin
            s    = prev;
            d    = (lst && close) ? head : $urandom_range(live_n - 1);
            prev = d;
          end
          default: begin
            s = $urandom_range(live_n - 1);
            d = $urandom_range(live_n - 1);
          end
        endcase
      end
      send_edge(s, d, ev, lst);
    end
  endtask

  initial begin
    int cfg_pick;
    int target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 6;
    rx_idle_pct <= 74;

    send_edge(63, 63, 1'b0, 1'b1);
    send_edge(63, 63, 1'b1, 1'b1);
    send_edge(0, 63, 1'b1, 1'b0);
    send_edge(63, 0, 1'b1, 1'b1);
    send_edge(5, 6, 1'b1, 1'b0);
    send_edge(5, 6, 1'b1, 1'b1);
    send_edge(7, 7, 1'b0, 1'b0);
    send_edge(1, 2, 1'b1, 1'b1);
    // A cycle loaded under 64 nodes lies outside the graph once the count drops.
    send_edge(10, 11, 1'b1, 1'b0);
    send_edge(11, 10, 1'b1, 1'b0);
    write_node_count(8);
    send_edge(0, 0, 1'b0, 1'b1);
    write_node_count(3);
    send_edge(5, 5, 1'b1, 1'b0);
    send_edge(0, 1, 1'b1, 1'b1);
    send_edge(1, 2, 1'b1, 1'b0);
    send_edge(2, 0, 1'b1, 1'b1);
    write_node_count(0);
    send_edge(0, 0, 1'b1, 1'b1);
    write_node_count(127);
    send_edge(63, 63, 1'b1, 1'b1);
    write_node_count(65);
    send_edge(63, 62, 1'b1, 1'b0);
    send_edge(62, 63, 1'b1, 1'b1);
    write_node_count(1);
    send_edge(0, 0, 1'b1, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 74 : 0;
      rx_idle_pct <= (mode == 0) ? 74 : (mode == 1) ? 6 : 0;
      if (mode != 1) begin
        // Small graphs keep coming while the receiver holds off, so the block
        // fills up and stalls its input.
        write_node_count(4);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (4) run_graph(GK_RING, 3);
      end
      target = items_sent + 195;
      while (items_sent < target) begin
        cfg_pick = $urandom_range(99);
        if (cfg_pick < 70) write_node_count($urandom_range(12, 1));
        else if (cfg_pick < 82) write_node_count($urandom_range(64, 13));
        else if (cfg_pick < 86) write_node_count(64);
        else if (cfg_pick < 90) write_node_count(0);
        else if (cfg_pick < 95) write_node_count(1);
        else write_node_count($urandom_range(127, 65));
        repeat (5) begin
          if (items_sent < target)
            run_graph(graph_kind_t'($urandom_range(2)),
                      ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(10, 1));
        end
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dgcd_pkg.sv
sv/dgcd_ram.sv
sv/dgcd_ctrl.sv
sv/dgcd_dp.sv
sv/directed_graph_cycle_detect_unit.sv
tb/graph_cycle_checker.sv
tb/directed_graph_cycle_detect_unit_tb.sv
